FILE: rtl/chg_pkg.sv
// Shared types, constants and small lookup functions for the color harmony generator.
// No dependencies; imported by every other file of the block.
package chg_pkg;

  localparam logic [2:0] OP_COMP  = 3'd0;
  localparam logic [2:0] OP_SPLIT = 3'd1;
  localparam logic [2:0] OP_ANLG  = 3'd2;
  localparam logic [2:0] OP_TRIAD = 3'd3;
  localparam logic [2:0] OP_TETR  = 3'd4;

  localparam logic [15:0] HUE_FULL   = 16'd23040;  // 360 degrees in 1/64 degree
  localparam logic [11:0] HUE_SECTOR = 12'd3840;   // 60 degrees
  localparam logic [7:0]  CH_MAX     = 8'd255;
  localparam logic [15:0] L_HALF     = 16'd16384;  // 0.5 in Q1.15

  // One queue entry: the base color in HSL (c already derived) plus the raw color.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [14:0] h;
    logic [15:0] c;
    logic [15:0] l;
  } hsl_t;

  // Number of result colors per mode.
  function automatic logic [1:0] res_count(input logic [2:0] op);
    logic [1:0] n;
    case (op)
      OP_COMP: n = 2'd1;
      OP_TETR: n = 2'd3;
      default: n = 2'd2;
    endcase
    return n;
  endfunction

  // Hue rotation in 1/64 degree for result idx of a mode.
  function automatic logic [14:0] angle_off(input logic [2:0] op, input logic [1:0] idx);
    logic [14:0] a;
    case (op)
      OP_SPLIT: a = (idx == 2'd0) ? 15'd13440 : 15'd9600;   // +210, +150
      OP_ANLG:  a = (idx == 2'd0) ? 15'd1920  : 15'd21120;  // +30, -30
      OP_TRIAD: a = (idx == 2'd0) ? 15'd7680  : 15'd15360;  // +120, +240
      OP_TETR: begin
        case (idx)
          2'd0:    a = 15'd5760;   // +90
          2'd1:    a = 15'd11520;  // +180
          default: a = 15'd17280;  // +270
        endcase
      end
      default:  a = 15'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/chg_front.sv
// Front end: takes input transfers and converts RGB to hue / chroma / lightness.
// Two restoring dividers (saturation, hue) run side by side, one quotient bit per stage;
// lightness is a constant division done by reciprocal multiplication. Uses chg_pkg.
module chg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  logic [2:0]    op_i,
  input  logic [7:0]    red_in_i,
  input  logic [7:0]    green_in_i,
  input  logic [7:0]    blue_in_i,
  input  logic          full_i,
  output logic          push_o,
  output chg_pkg::hsl_t ent_o
);
  import chg_pkg::*;

  localparam int unsigned NSTEP = 16;

  typedef struct packed {
    logic [8:0]  rem;
    logic [15:0] nq;   // remaining numerator bits on top, quotient bits shift in below
    logic [8:0]  dv;
  } lane_t;

  typedef struct packed {
    logic [15:0] lum;
    lane_t       sat;
    lane_t       hue;
    logic [2:0]  op;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        grey;
    logic        neg;
    logic [1:0]  sel;
  } dstage_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [14:0] h;
    logic [15:0] s;
    logic [15:0] l;
  } fin_t;

  function automatic lane_t lane_step(input lane_t a);
    lane_t      o;
    logic [9:0] t;
    logic       ge;
    t     = {a.rem, a.nq[15]};
    ge    = (t >= {1'b0, a.dv});
    o     = a;
    o.rem = ge ? 9'(t - {1'b0, a.dv}) : t[8:0];
    o.nq  = {a.nq[14:0], ge};
    return o;
  endfunction

  function automatic lane_t lane_init(input logic [23:0] num, input logic [8:0] dv);
    lane_t o;
    o.rem = {1'b0, num[23:16]};
    o.nq  = num[15:0];
    o.dv  = dv;
    return o;
  endfunction

  function automatic dstage_t stage_step(input dstage_t a);
    dstage_t o;
    o     = a;
    o.sat = lane_step(a.sat);
    o.hue = lane_step(a.hue);
    return o;
  endfunction

  logic        en;
  logic        s0_v_q;
  logic [2:0]  s0_op_q;
  logic [7:0]  s0_r_q, s0_g_q, s0_b_q;
  logic        dv_v_q [NSTEP+1];
  dstage_t     dv_q   [NSTEP+1];
  logic        f_v_q;
  fin_t        f_q;
  logic        c_v_q;
  hsl_t        c_q;

  // stage 1 classification
  logic [7:0]  mx, mn, d, mag;
  logic [8:0]  sum, sdiv;
  logic [1:0]  sel;
  logic        neg;
  logic [15:0] ly;
  logic [23:0] lrec;
  dstage_t     s1;

  // finish stage
  dstage_t     dl;
  logic [15:0] base, qh, hv;
  fin_t        fin;

  // chroma stage
  logic [16:0] l2, lop;
  logic [32:0] cp;
  hsl_t        cn;

  assign en      = !c_v_q || !full_i;
  assign stall_o = !en;
  assign push_o  = c_v_q && !full_i;
  assign ent_o   = c_q;

  always_comb begin
    mx = s0_r_q;
    mn = s0_r_q;
    if (s0_g_q > mx) mx = s0_g_q;
    if (s0_b_q > mx) mx = s0_b_q;
    if (s0_g_q < mn) mn = s0_g_q;
    if (s0_b_q < mn) mn = s0_b_q;
    d    = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    sdiv = (sum < 9'd255) ? sum : 9'(9'd510 - sum);
    if (d == 8'd0) sdiv = 9'd1;
    if (mx == s0_r_q) begin
      sel = 2'd0;
      neg = s0_g_q < s0_b_q;
      mag = neg ? s0_b_q - s0_g_q : s0_g_q - s0_b_q;
    end else if (mx == s0_g_q) begin
      sel = 2'd1;
      neg = s0_b_q < s0_r_q;
      mag = neg ? s0_r_q - s0_b_q : s0_b_q - s0_r_q;
    end else begin
      sel = 2'd2;
      neg = s0_r_q < s0_g_q;
      mag = neg ? s0_g_q - s0_r_q : s0_r_q - s0_g_q;
    end
    // L = (sum*32768 + 255) / 510 = 64*sum + (64*sum + 127) / 255,
    // the last term by reciprocal: floor(y/255) = ((y+1)*257) >> 16 for y < 32768
    ly     = {1'b0, sum, 6'd0} + 16'd128;
    lrec   = 24'(ly) * 24'd257;
    s1.lum = {1'b0, sum, 6'd0} + {8'd0, lrec[23:16]};
    s1.sat  = lane_init({1'b0, d, 15'd0}, sdiv);
    s1.hue  = lane_init(24'(mag) * 24'(HUE_SECTOR), (d == 8'd0) ? 9'd1 : {1'b0, d});
    s1.op   = s0_op_q;
    s1.r    = s0_r_q;
    s1.g    = s0_g_q;
    s1.b    = s0_b_q;
    s1.grey = (d == 8'd0);
    s1.neg  = neg;
    s1.sel  = sel;
  end

  always_comb begin
    dl = dv_q[NSTEP];
    qh = dl.hue.nq;
    case (dl.sel)
      2'd0:    base = 16'd0;
      2'd1:    base = 16'd7680;
      default: base = 16'd15360;
    endcase
    if (!dl.neg) hv = base + qh;
    else if (qh > base) hv = base + HUE_FULL - qh;
    else hv = base - qh;
    fin.op = dl.op;
    fin.r  = dl.r;
    fin.g  = dl.g;
    fin.b  = dl.b;
    fin.h  = dl.grey ? 15'd0 : hv[14:0];
    fin.s  = dl.grey ? 16'd0 : dl.sat.nq;
    fin.l  = dl.lum;
  end

  always_comb begin
    l2    = {f_q.l, 1'b0};
    lop   = (f_q.l <= L_HALF) ? l2 : 17'(17'h10000 - l2);
    cp    = 33'(f_q.s) * 33'(lop);
    cn.op = f_q.op;
    cn.r  = f_q.r;
    cn.g  = f_q.g;
    cn.b  = f_q.b;
    cn.h  = f_q.h;
    cn.c  = cp[30:15];
    cn.l  = f_q.l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      for (int i = 0; i <= NSTEP; i++) dv_v_q[i] <= 1'b0;
      f_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
    end else if (en) begin
      // undefined modes are taken and dropped here
      s0_v_q    <= valid_i && (op_i <= OP_TETR);
      dv_v_q[0] <= s0_v_q;
      for (int i = 1; i <= NSTEP; i++) dv_v_q[i] <= dv_v_q[i-1];
      f_v_q     <= dv_v_q[NSTEP];
      c_v_q     <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_op_q <= op_i;
      s0_r_q  <= red_in_i;
      s0_g_q  <= green_in_i;
      s0_b_q  <= blue_in_i;
      dv_q[0] <= s1;
      for (int i = 1; i <= NSTEP; i++) dv_q[i] <= stage_step(dv_q[i-1]);
      f_q <= fin;
      c_q <= cn;
    end
  end

endmodule

FILE: rtl/chg_queue.sv
// Small FIFO of converted colors between front end and back end.
// Uses chg_pkg for the entry type.
module chg_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  chg_pkg::hsl_t ent_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          nempty_o,
  output chg_pkg::hsl_t ent_o
);
  import chg_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hsl_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o   = (cnt_q == CW'(DEPTH));
  assign nempty_o = (cnt_q != '0);
  assign ent_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ent_i;
  end

endmodule

FILE: rtl/chg_back.sv
// Back end: issues one rotated hue per cycle from the queue head unless empty or stalled
// and turns it into RGB. Six-stage pipeline ending in the output register. Uses chg_pkg.
module chg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          nempty_i,
  input  chg_pkg::hsl_t ent_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [7:0]    red_out_o,
  output logic [7:0]    green_out_o,
  output logic [7:0]    blue_out_o,
  output logic          last_o
);
  import chg_pkg::*;

  typedef struct packed {
    logic [2:0]  k;
    logic [15:0] c;
    logic [15:0] m;
    logic        comp;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
  } side_t;

  function automatic logic [7:0] chan(input logic [15:0] part, input logic [15:0] m);
    logic [16:0] s;
    logic [24:0] p;
    s = {1'b0, part} + {1'b0, m};
    p = {s, 8'd0} - 25'(s);
    return (p[24:15] > 10'd255) ? CH_MAX : p[22:15];
  endfunction

  logic        en, issue, ilast;
  logic [1:0]  idx_q;
  logic        a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, o_v_q;
  hsl_t        a_ent_q;
  logic [1:0]  a_idx_q;
  logic        a_last_q;
  side_t       b_s_q, c_s_q, d_s_q, e_s_q;
  logic [11:0] b_fp_q;
  logic [26:0] c_p_q;
  logic [18:0] d_v_q19;
  logic [18:0] d_q0_q;
  logic [15:0] e_x_q;
  logic [7:0]  o_r_q, o_g_q, o_b_q;
  logic        o_last_q;

  // stage A logic
  logic [15:0] hsum, hr;
  logic [2:0]  k;
  logic [15:0] f;
  logic [11:0] fp;
  logic [15:0] ch;
  side_t       sa;
  // later stages
  logic [26:0] pn;
  logic [34:0] rp;
  logic [18:0] rem;
  logic [15:0] xn;
  logic [15:0] pr, pg, pb;

  assign en    = !o_v_q || !stall_i;
  assign issue = nempty_i && en;
  assign ilast = (idx_q == 2'(res_count(ent_i.op) - 2'd1));
  assign pop_o = issue && ilast;

  always_comb begin
    hsum = {1'b0, a_ent_q.h} + {1'b0, angle_off(a_ent_q.op, a_idx_q)};
    hr   = (hsum >= HUE_FULL) ? hsum - HUE_FULL : hsum;
    if      (hr >= 16'd19200) k = 3'd5;
    else if (hr >= 16'd15360) k = 3'd4;
    else if (hr >= 16'd11520) k = 3'd3;
    else if (hr >= 16'd7680)  k = 3'd2;
    else if (hr >= 16'd3840)  k = 3'd1;
    else                      k = 3'd0;
    f  = hr - 16'(k) * 16'(HUE_SECTOR);
    fp = k[0] ? 12'(HUE_SECTOR - f[11:0]) : f[11:0];
    ch = {1'b0, a_ent_q.c[15:1]};
    sa.k    = k;
    sa.c    = a_ent_q.c;
    sa.m    = (ch > a_ent_q.l) ? 16'd0 : a_ent_q.l - ch;
    sa.comp = (a_ent_q.op == OP_COMP);
    sa.r    = a_ent_q.r;
    sa.g    = a_ent_q.g;
    sa.b    = a_ent_q.b;
    sa.last = a_last_q;
  end

  // x = c*f/3840: product, then /256 as a shift and /15 by reciprocal with one fixup
  assign pn  = 27'(b_s_q.c) * 27'(b_fp_q);
  assign rp  = 35'(c_p_q[26:8]) * 35'd34952;
  assign rem = d_v_q19 - 19'(d_q0_q * 19'd15);
  assign xn  = (rem >= 19'd15) ? 16'(d_q0_q + 19'd1) : d_q0_q[15:0];

  always_comb begin
    case (e_s_q.k)
      3'd0:    begin pr = e_s_q.c; pg = e_x_q;   pb = 16'd0;   end
      3'd1:    begin pr = e_x_q;   pg = e_s_q.c; pb = 16'd0;   end
      3'd2:    begin pr = 16'd0;   pg = e_s_q.c; pb = e_x_q;   end
      3'd3:    begin pr = 16'd0;   pg = e_x_q;   pb = e_s_q.c; end
      3'd4:    begin pr = e_x_q;   pg = 16'd0;   pb = e_s_q.c; end
      default: begin pr = e_s_q.c; pg = 16'd0;   pb = e_x_q;   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      if (issue) idx_q <= ilast ? 2'd0 : idx_q + 2'd1;
      a_v_q <= issue;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      o_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ent_q  <= ent_i;
      a_idx_q  <= idx_q;
      a_last_q <= ilast;
      b_s_q    <= sa;
      b_fp_q   <= fp;
      c_s_q    <= b_s_q;
      c_p_q    <= pn;
      d_s_q    <= c_s_q;
      d_v_q19  <= c_p_q[26:8];
      d_q0_q   <= 19'(rp[34:19]);
      e_s_q    <= d_s_q;
      e_x_q    <= xn;
      o_r_q    <= e_s_q.comp ? CH_MAX - e_s_q.r : chan(pr, e_s_q.m);
      o_g_q    <= e_s_q.comp ? CH_MAX - e_s_q.g : chan(pg, e_s_q.m);
      o_b_q    <= e_s_q.comp ? CH_MAX - e_s_q.b : chan(pb, e_s_q.m);
      o_last_q <= e_s_q.last;
    end
  end

  assign valid_o     = o_v_q;
  assign red_out_o   = o_r_q;
  assign green_out_o = o_g_q;
  assign blue_out_o  = o_b_q;
  assign last_o      = o_last_q;

endmodule

FILE: rtl/color_harmony_generator.sv
// Color harmony generator: RGB color plus harmony mode in, one to three harmony colors out.
// Top level; instantiates chg_front, chg_queue and chg_back, uses chg_pkg.
//
// Each input transfer carries an 8-bit RGB color and a mode: complementary (one color,
// each channel inverted), split complementary (+210, +150 degrees), analogous (+30, -30),
// triadic (+120, +240) or tetradic (+90, +180, +270). Results leave in that order, one
// per output transfer, with last_o set on the final color of an input. Modes 5..7 are
// taken and produce nothing. The front end takes one input per cycle unless it stalls and
// converts to hue/saturation/lightness through two bit-serial divider lanes (16 stages);
// a queue of QUEUE_DEPTH entries sits between it and the back end. The back end issues
// one result per cycle unless stall_i holds it, so throughput depends on results per input:
// one for complementary, two for split/analogous/triadic, three for tetradic.
// The queue lets a new input be taken while a result waits on stall_i, until it fills.
module color_harmony_generator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [2:0] op_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic       last_o
);
  import chg_pkg::*;

  logic full, push, pop, nempty;
  hsl_t ent_in, ent_out;

  chg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .op_i       (op_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .full_i     (full),
    .push_o     (push),
    .ent_o      (ent_in)
  );

  chg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .ent_i    (ent_in),
    .full_o   (full),
    .pop_i    (pop),
    .nempty_o (nempty),
    .ent_o    (ent_out)
  );

  chg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nempty_i    (nempty),
    .ent_i       (ent_out),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .last_o      (last_o)
  );

endmodule

FILE: tb/color_harmony_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the color harmony generator.
// Drives mode plus RGB transfers, predicts the harmony colors, and checks every result.
module color_harmony_generator_tb;
  import chg_pkg::*;

  // One base color and harmony mode, as offered on the input port.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_req_t;

  // One harmony color, as seen on the output port.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } harmony_t;

  logic       clk_i;
  logic       rst_ni;
  logic       valid_i    = 1'b0;
  logic       stall_o;
  logic [2:0] op_i       = '0;
  logic [7:0] red_in_i   = '0;
  logic [7:0] green_in_i = '0;
  logic [7:0] blue_in_i  = '0;
  logic       valid_o;
  logic       stall_i    = 1'b0;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       last_o;

  color_harmony_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .op_i        (op_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .last_o      (last_o)
  );

  color_req_t pending_colors[$];    // waiting for the driver
  harmony_t   expected_colors[$];   // predicted, not yet seen on the output
  int         error_count   = 0;
  bit         hold_sender   = 0;    // sender waits for the output side to drain
  bit         hold_receiver = 0;    // request for a long output stall
  bit         in_fire_q     = 0;    // input transfer happened at the last rising edge
  int         rx_hold_cnt   = 0;
  int         tx_gap        = 0;
  int         rx_gap        = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Random gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Channel from a Q1.15 part plus offset, scaled to 0..255 and clamped.
  function automatic logic [7:0] q15_to_chan(input logic [31:0] part, input logic [31:0] m);
    logic [31:0] v;
    v = ((part + m) * 32'd255) >> 15;
    return (v > 32'd255) ? 8'd255 : v[7:0];
  endfunction

  // Hue rotation in degrees for result idx of a mode.
  function automatic int rot_degrees(input logic [2:0] op, input int idx);
    case (op)
      OP_SPLIT: return (idx == 0) ? 210 : 150;
      OP_ANLG:  return (idx == 0) ? 30 : 330;
      OP_TRIAD: return (idx == 0) ? 120 : 240;
      default:  return (idx == 0) ? 90 : (idx == 1) ? 180 : 270;
    endcase
  endfunction

  // Works out the harmony colors of one accepted transfer and queues them.
  task automatic predict_harmonies(input color_req_t req);
    int mx, mn, d, sum, t, n, k, f;
    int r, g, b;
    logic [31:0] hue, sat, lum, hr, c, x, m, pr, pg, pb;
    harmony_t res;
    r = req.r; g = req.g; b = req.b;
    if (req.op > OP_TETR) return;   // undefined mode: taken, nothing comes out
    if (req.op == OP_COMP) begin
      res.r = 8'd255 - req.r;
      res.g = 8'd255 - req.g;
      res.b = 8'd255 - req.b;
      res.last = 1'b1;
      expected_colors.push_back(res);
      return;
    end
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    lum = (sum * 32768 + 255) / 510;
    if (d == 0) begin
      sat = 0; hue = 0;   // grey: every rotation gives the same grey
    end else begin
      sat = (sum < 255) ? (d * 32768) / sum : (d * 32768) / (510 - sum);
      if (mx == r) t = ((g - b) * 3840) / d;
      else if (mx == g) t = 7680 + ((b - r) * 3840) / d;
      else t = 15360 + ((r - g) * 3840) / d;
      if (t < 0) t += 23040;
      hue = t % 23040;
    end
    n = (req.op == OP_TETR) ? 3 : 2;
    for (int i = 0; i < n; i++) begin
      hr = (hue + rot_degrees(req.op, i) * 64) % 23040;
      if (lum <= 16384) c = (sat * (2 * lum)) >> 15;
      else c = (sat * (65536 - 2 * lum)) >> 15;
      k = hr / 3840;
      f = hr % 3840;
      x = (k % 2 == 0) ? (c * f) / 3840 : (c * (3840 - f)) / 3840;
      m = ((c >> 1) > lum) ? 0 : lum - (c >> 1);
      case (k)
        0:       begin pr = c; pg = x; pb = 0; end
        1:       begin pr = x; pg = c; pb = 0; end
        2:       begin pr = 0; pg = c; pb = x; end
        3:       begin pr = 0; pg = x; pb = c; end
        4:       begin pr = x; pg = 0; pb = c; end
        default: begin pr = c; pg = 0; pb = x; end
      endcase
      res.r = q15_to_chan(pr, m);
      res.g = q15_to_chan(pg, m);
      res.b = q15_to_chan(pb, m);
      res.last = (i == n - 1);
      expected_colors.push_back(res);
    end
  endtask

  function automatic color_req_t mk_color(input logic [2:0] op, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
    color_req_t req;
    req.op = op; req.r = r; req.g = g; req.b = b;
    return req;
  endfunction

  // Driver: presents transfers at the falling edge; payload holds while stalled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else if (valid_i && !in_fire_q) begin
      // offered but not taken yet: hold everything
    end else if (hold_sender) begin
      valid_i <= 1'b0;
    end else if (tx_gap > 0) begin
      tx_gap  <= tx_gap - 1;
      valid_i <= 1'b0;
    end else if (pending_colors.size() > 0) begin
      color_req_t req;
      req = pending_colors.pop_front();
      valid_i    <= 1'b1;
      op_i       <= req.op;
      red_in_i   <= req.r;
      green_in_i <= req.g;
      blue_in_i  <= req.b;
      tx_gap     <= pick_gap();
    end else begin
      valid_i <= 1'b0;
    end
  end

  // Predict on the accepting edge.
  always @(posedge clk_i) begin
    in_fire_q <= rst_ni && valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o)
      predict_harmonies(mk_color(op_i, red_in_i, green_in_i, blue_in_i));
  end

  // Receiver stall: random gaps, plus one long hold-off counted here.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else if (hold_receiver && rx_hold_cnt == 0) begin
      rx_hold_cnt <= 400;
      stall_i     <= 1'b1;
    end else if (rx_hold_cnt > 1) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      stall_i     <= 1'b1;
    end else if (rx_hold_cnt == 1) begin
      rx_hold_cnt <= -1;   // done, never again
      stall_i     <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap  <= rx_gap - 1;
      stall_i <= 1'b1;
    end else begin
      rx_gap  <= pick_gap();
      stall_i <= 1'b0;
    end
  end

  // Monitor: each output transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected result r=%0d g=%0d b=%0d last=%0b",
               red_out_o, green_out_o, blue_out_o, last_o);
        error_count++;
      end else begin
        harmony_t exp_c;
        exp_c = expected_colors.pop_front();
        if (red_out_o !== exp_c.r) begin
          $error("red_out: expected %0d, got %0d", exp_c.r, red_out_o);
          error_count++;
        end
        if (green_out_o !== exp_c.g) begin
          $error("green_out: expected %0d, got %0d", exp_c.g, green_out_o);
          error_count++;
        end
        if (blue_out_o !== exp_c.b) begin
          $error("blue_out: expected %0d, got %0d", exp_c.b, blue_out_o);
          error_count++;
        end
        if (last_o !== exp_c.last) begin
          $error("last: expected %0b, got %0b", exp_c.last, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_colors.size() > 0 || valid_i || expected_colors.size() > 0)
      @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_chan();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int sel;
    logic [7:0] v;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every mode, grey, undefined modes, each hue max channel.
    pending_colors.push_back(mk_color(OP_COMP, 8'd0, 8'd0, 8'd0));
    pending_colors.push_back(mk_color(OP_COMP, 8'd255, 8'd255, 8'd255));
    pending_colors.push_back(mk_color(OP_COMP, 8'd18, 8'd200, 8'd77));
    pending_colors.push_back(mk_color(OP_SPLIT, 8'd255, 8'd0, 8'd0));
    pending_colors.push_back(mk_color(OP_ANLG, 8'd0, 8'd255, 8'd0));
    pending_colors.push_back(mk_color(OP_TRIAD, 8'd0, 8'd0, 8'd255));
    pending_colors.push_back(mk_color(OP_TETR, 8'd255, 8'd255, 8'd0));
    pending_colors.push_back(mk_color(OP_TETR, 8'd128, 8'd128, 8'd128));
    pending_colors.push_back(mk_color(OP_SPLIT, 8'd0, 8'd0, 8'd0));
    pending_colors.push_back(mk_color(OP_ANLG, 8'd255, 8'd255, 8'd255));
    pending_colors.push_back(mk_color(3'd5, 8'd10, 8'd20, 8'd30));
    pending_colors.push_back(mk_color(3'd6, 8'd255, 8'd0, 8'd255));
    pending_colors.push_back(mk_color(3'd7, 8'd255, 8'd255, 8'd255));
    pending_colors.push_back(mk_color(OP_TRIAD, 8'd200, 8'd50, 8'd100));
    pending_colors.push_back(mk_color(OP_TETR, 8'd1, 8'd254, 8'd0));
    pending_colors.push_back(mk_color(OP_SPLIT, 8'd127, 8'd128, 8'd255));
    pending_colors.push_back(mk_color(OP_ANLG, 8'd255, 8'd254, 8'd255));
    pending_colors.push_back(mk_color(OP_TETR, 8'd0, 8'd255, 8'd255));
    wait_drained();

    // Long output hold-off while the sender keeps going: the block must fill and stall.
    hold_receiver = 1;
    for (int i = 0; i < 40; i++)
      pending_colors.push_back(mk_color($urandom_range(0, 4), rand_chan(), rand_chan(),
                                        rand_chan()));
    wait_drained();
    hold_receiver = 0;

    // Random traffic, with one sender pause until the output side drains.
    for (int i = 0; i < 120; i++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        pending_colors.push_back(mk_color($urandom_range(5, 7), rand_chan(), rand_chan(),
                                          rand_chan()));
      end else begin
        if (sel == 1) begin
          v = rand_chan();
          pending_colors.push_back(mk_color($urandom_range(0, 4), v, v, v));
        end else begin
          pending_colors.push_back(mk_color($urandom_range(0, 4), rand_chan(),
                                            rand_chan(), rand_chan()));
        end
      end
      if (i == 70) begin
        hold_sender = 1;
        while (valid_i || expected_colors.size() > 0) @(posedge clk_i);
        hold_sender = 0;
      end
      while (pending_colors.size() > 4) @(posedge clk_i);
    end
    wait_drained();
    // Modes 5..7 leave nothing to wait for; let the pipeline settle.
    repeat (100) @(posedge clk_i);

    if (error_count == 0)
      $display("** color_harmony_generator: PASSED **");
    else
      $display("** color_harmony_generator: FAILED **");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("** color_harmony_generator: FAILED **");
    $finish;
  end

endmodule
